// ===== hw/rtl/mvm_pkg.sv =====
// mvm_pkg: shared types, constants and helpers of the matrix-vector multiply block
// used by mvm_regs, mvm_ctrl, mvm_dpath and matrix_vector_multiply
package mvm_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 48;
  localparam int ROW_IDX_W = 10;
  localparam int DIM_W     = 11;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int CLAMP_W   = 17;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } reg_idx_t;

  localparam logic [DIM_W-1:0] NUM_COLS_RST = DIM_W'(1024);
  localparam logic [DIM_W-1:0] NUM_ROWS_RST = DIM_W'(1024);

  // input mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_we;
    logic mat_start;
    logic mul_en;
    logic acc_en;
    logic row_done;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_end;
  } dp_stat_t;

  // effective dimension: zero counts as one, large values saturate
  function automatic logic [CLAMP_W-1:0] mvm_clamp(input logic [DIM_W-1:0] v,
                                                    input int maxv);
    logic [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = CLAMP_W'(1);
    end else if (int'(v) > maxv) begin
      r = CLAMP_W'(maxv);
    end else begin
      r = CLAMP_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/matrix_vector_multiply.sv =====
// matrix_vector_multiply: top level of the streaming y = A*x block
// depends on mvm_pkg, mvm_regs, mvm_ctrl and mvm_dpath
//
// Vector load requests (in_mode 0) leave busy low and fill the vector store in
// order. Matrix requests (in_mode 1) stream row-major and pass through three
// steps: a registered read of the vector store, a registered 16x16 multiply,
// then the 48-bit accumulate, so busy is high in the multiply and accumulate
// steps after a matrix request is accepted. A request is accepted when start is
// high and busy is low. After the last column of a row, out_valid is high for
// exactly one cycle with the row sum, row index and last-row flag; the receiver
// cannot stall the block, so it must take every result as it appears.
module matrix_vector_multiply #(
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic signed [mvm_pkg::ELEM_W-1:0]   in_elem_value,
  output logic                                out_valid,
  output logic signed [mvm_pkg::SUM_W-1:0]    out_row_sum,
  output logic [mvm_pkg::ROW_IDX_W-1:0]       out_row_index,
  output logic                                out_last_row,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvm_pkg::APB_AW-1:0]          paddr,
  input  logic [mvm_pkg::APB_DW-1:0]          pwdata,
  output logic [mvm_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import mvm_pkg::*;

  logic [DIM_W-1:0] num_cols;
  logic [DIM_W-1:0] num_rows;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  mvm_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .num_cols (num_cols),
    .num_rows (num_rows)
  );

  mvm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  mvm_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_elem_value (in_elem_value),
    .num_cols      (num_cols),
    .num_rows      (num_rows),
    .out_valid     (out_valid),
    .out_row_sum   (out_row_sum),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

endmodule

// ===== hw/rtl/mvm_regs.sv =====
// mvm_regs: apb configuration registers num_cols and num_rows
// depends on mvm_pkg
module mvm_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvm_pkg::APB_AW-1:0]  paddr,
  input  logic [mvm_pkg::APB_DW-1:0]  pwdata,
  output logic [mvm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [mvm_pkg::DIM_W-1:0]   num_cols,
  output logic [mvm_pkg::DIM_W-1:0]   num_rows
);
  import mvm_pkg::*;

  logic [DIM_W-1:0] num_cols_r, num_cols_nxt;
  logic [DIM_W-1:0] num_rows_r, num_rows_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    num_cols_nxt = num_cols_r;
    num_rows_nxt = num_rows_r;
    if (wr_en) begin
      unique case (idx)
        REG_NUM_COLS: num_cols_nxt = pwdata[DIM_W-1:0];
        REG_NUM_ROWS: num_rows_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NUM_COLS: prdata = APB_DW'(num_cols_r);
      REG_NUM_ROWS: prdata = APB_DW'(num_rows_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_RST;
      num_rows_r <= NUM_ROWS_RST;
    end else begin
      num_cols_r <= num_cols_nxt;
      num_rows_r <= num_rows_nxt;
    end
  end

  assign num_cols = num_cols_r;
  assign num_rows = num_rows_r;

endmodule

// ===== hw/rtl/mvm_ctrl.sv =====
// mvm_ctrl: sequencer for vector loads and matrix multiply-accumulate steps
// depends on mvm_pkg
module mvm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_mode,
  input  mvm_pkg::dp_stat_t  stat,
  output mvm_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import mvm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ACC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    state_nxt     = state_r;
    cmd.load_we   = 1'b0;
    cmd.mat_start = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.acc_en    = 1'b0;
    cmd.row_done  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.mat_start = 1'b1;
            state_nxt     = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        // close the row in this same step when the last column is reported
        cmd.acc_en   = 1'b1;
        cmd.row_done = stat.col_end;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/mvm_dpath.sv =====
// mvm_dpath: vector store, multiplier, row accumulator, counters and result register
// depends on mvm_pkg
module mvm_dpath #(
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mvm_pkg::dp_cmd_t                   cmd,
  output mvm_pkg::dp_stat_t                  stat,
  input  logic signed [mvm_pkg::ELEM_W-1:0]  in_elem_value,
  input  logic [mvm_pkg::DIM_W-1:0]          num_cols,
  input  logic [mvm_pkg::DIM_W-1:0]          num_rows,
  output logic                               out_valid,
  output logic signed [mvm_pkg::SUM_W-1:0]   out_row_sum,
  output logic [mvm_pkg::ROW_IDX_W-1:0]      out_row_index,
  output logic                               out_last_row
);
  import mvm_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ELEM_W-1:0] vec_mem [MAX_COLS];

  logic [CW-1:0]              load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]              col_cnt_r,  col_cnt_nxt;
  logic [RW-1:0]              row_cnt_r,  row_cnt_nxt;
  logic signed [SUM_W-1:0]    acc_r,      acc_nxt;
  logic signed [ELEM_W-1:0]   val_r;
  logic signed [ELEM_W-1:0]   rd_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic [ROW_IDX_W-1:0]       out_idx_r;
  logic                       out_last_r;

  logic [CW:0]             ncols;
  logic [RW:0]             nrows;
  logic [CW:0]             load_inc;
  logic [CW:0]             col_inc;
  logic [RW:0]             row_inc;
  logic                    row_last;
  logic signed [SUM_W-1:0] sum;

  assign ncols    = (CW+1)'(mvm_clamp(num_cols, MAX_COLS));
  assign nrows    = (RW+1)'(mvm_clamp(num_rows, MAX_ROWS));
  assign load_inc = {1'b0, load_cnt_r} + (CW+1)'(1);
  assign col_inc  = {1'b0, col_cnt_r} + (CW+1)'(1);
  assign row_inc  = {1'b0, row_cnt_r} + (RW+1)'(1);
  assign row_last = (row_inc >= nrows);
  assign sum      = acc_r + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign stat.col_end = (col_inc >= ncols);

  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    if (cmd.load_we) begin
      // wrap after the last vector entry
      load_cnt_nxt = (load_inc >= ncols) ? '0 : load_inc[CW-1:0];
    end
    if (cmd.acc_en) begin
      if (cmd.row_done) begin
        out_valid_nxt = 1'b1;
        acc_nxt       = '0;
        col_cnt_nxt   = '0;
        row_cnt_nxt   = row_last ? '0 : row_inc[RW-1:0];
      end else begin
        acc_nxt     = sum;
        col_cnt_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_cnt_r  <= load_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // vector store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      vec_mem[load_cnt_r] <= in_elem_value;
    end
    if (cmd.mat_start) begin
      rd_r <= vec_mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_start) begin
      val_r <= in_elem_value;
    end
    if (cmd.mul_en) begin
      prod_r <= val_r * rd_r;
    end
    if (cmd.acc_en && cmd.row_done) begin
      out_sum_r  <= sum;
      out_idx_r  <= ROW_IDX_W'(row_cnt_r);
      out_last_r <= row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_sum   = out_sum_r;
  assign out_row_index = out_idx_r;
  assign out_last_row  = out_last_r;

endmodule

// ===== bench/matrix_vector_multiply_test.sv =====
// matrix_vector_multiply_test: self-checking bench for the streaming y = A*x block
// drives vector loads, matrix elements and register writes, predicts every row sum
// depends on mvm_pkg and matrix_vector_multiply
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int VEC_DEPTH    = DEF_MAX_COLS;
  localparam int ROW_LIMIT    = DEF_MAX_ROWS;
  localparam int DRAIN_CYCLES = 8;
  localparam int FILL_DEPTH   = 16;

  typedef struct packed {
    logic              mode;
    logic [ELEM_W-1:0] value;
  } elem_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [ROW_IDX_W-1:0] idx;
    logic                 last;
  } row_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_mode = MODE_LOAD;
  logic signed [ELEM_W-1:0] in_elem_value = '0;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_row_sum;
  logic [ROW_IDX_W-1:0]     out_row_index;
  logic                     out_last_row;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  matrix_vector_multiply u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_row_sum   (out_row_sum),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  // shadow of the block: vector store, counters, accumulator and dimension registers
  logic signed [ELEM_W-1:0] vec_mem [VEC_DEPTH];
  logic [DIM_W-1:0]         cfg_cols = NUM_COLS_RST;
  logic [DIM_W-1:0]         cfg_rows = NUM_ROWS_RST;
  int                       load_ptr = 0;
  int                       col_ptr = 0;
  int                       row_ptr = 0;
  logic [SUM_W-1:0]         acc_model = '0;

  elem_req_t   pending_reqs [$];
  row_result_t row_sums_due [$];
  elem_req_t   next_req;
  row_result_t want;
  int          idle_pct = 0;
  int          errors = 0;
  int          n_loads = 0;
  int          n_matrix = 0;
  int          n_rows = 0;
  int          n_writes = 0;

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // advance the shadow by one accepted request and queue the row sum it completes
  task automatic take_request(input elem_req_t r);
    int                       ncols;
    int                       nrows;
    logic signed [PROD_W-1:0] prod;
    row_result_t              res;
    ncols = eff_dim(cfg_cols, VEC_DEPTH);
    nrows = eff_dim(cfg_rows, ROW_LIMIT);
    if (r.mode == MODE_LOAD) begin
      if (load_ptr >= VEC_DEPTH) load_ptr = 0;
      vec_mem[load_ptr] = r.value;
      load_ptr++;
      if (load_ptr >= ncols) load_ptr = 0;
      n_loads++;
    end else begin
      if (col_ptr >= VEC_DEPTH) col_ptr = 0;
      prod = $signed(r.value) * vec_mem[col_ptr];
      acc_model = acc_model + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
      col_ptr++;
      n_matrix++;
      if (col_ptr >= ncols) begin
        res.sum  = acc_model;
        res.idx  = ROW_IDX_W'(row_ptr);
        res.last = (row_ptr + 1 >= nrows);
        row_sums_due.push_back(res);
        acc_model = '0;
        col_ptr = 0;
        row_ptr = res.last ? 0 : row_ptr + 1;
      end
    end
  endtask

  // driver: hold a request until taken, then maybe idle before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        take_request('{mode: in_mode, value: in_elem_value});
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_reqs.pop_front();
        start <= 1'b1;
        in_mode <= next_req.mode;
        in_elem_value <= next_req.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe must match the oldest predicted row sum
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (row_sums_due.size() == 0) begin
        $display("%0t: row sum %0d row %0d with none expected", $time, out_row_sum,
                 out_row_index);
        errors++;
      end else begin
        want = row_sums_due.pop_front();
        n_rows++;
        if (out_row_sum !== want.sum) begin
          $display("%0t: row_sum expected %0d got %0d", $time, $signed(want.sum),
                   out_row_sum);
          errors++;
        end
        if (out_row_index !== want.idx) begin
          $display("%0t: row_index expected %0d got %0d", $time, want.idx, out_row_index);
          errors++;
        end
        if (out_last_row !== want.last) begin
          $display("%0t: last_row expected %0b got %0b", $time, want.last, out_last_row);
          errors++;
        end
      end
    end
  end

  function automatic logic [ELEM_W-1:0] pick_value();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(7))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: v = ELEM_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_req(input logic mode, input logic [ELEM_W-1:0] value);
    pending_reqs.push_back('{mode: mode, value: value});
  endtask

  // wait until every request is taken and every row sum has come out
  task automatic settle();
    do @(posedge clk); while (pending_reqs.size() != 0 || start || row_sums_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write, then read the register back
  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_NUM_COLS) cfg_cols = val;
    else cfg_rows = val;
    n_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(val)) begin
      $display("%0t: readback of register %0d expected %0d got %0d", $time, idx, val,
               prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // fresh vector, whole rows with stray loads mixed in, then a partial row left open
  task automatic run_phase(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                           input int idle, input int row_reqs);
    int nc;
    write_reg(REG_NUM_COLS, cols);
    write_reg(REG_NUM_ROWS, rows);
    idle_pct = idle;
    nc = eff_dim(cols, VEC_DEPTH);
    for (int i = 0; i < nc; i++) push_req(MODE_LOAD, pick_value());
    for (int r = 0; r < row_reqs; r++) begin
      for (int c = 0; c < nc; c++) begin
        if ($urandom_range(99) < 8) push_req(MODE_LOAD, pick_value());
        push_req(MODE_MATRIX, pick_value());
      end
    end
    for (int c = $urandom_range(nc - 1); c > 0; c--) push_req(MODE_MATRIX, pick_value());
    settle();
  endtask

  initial begin
    for (int i = 0; i < VEC_DEPTH; i++) vec_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fill every entry the widest phase reads so none is read unwritten; load pointer wraps
    idle_pct = 0;
    write_reg(REG_NUM_COLS, FILL_DEPTH);
    for (int i = 0; i < FILL_DEPTH; i++) push_req(MODE_LOAD, pick_value());
    settle();

    // extreme products, pass wrap after the last row
    write_reg(REG_NUM_COLS, 2);
    write_reg(REG_NUM_ROWS, 3);
    push_req(MODE_LOAD, 16'h8000);
    push_req(MODE_LOAD, 16'h7fff);
    push_req(MODE_MATRIX, 16'h8000);
    push_req(MODE_MATRIX, 16'h8000);
    push_req(MODE_MATRIX, 16'h7fff);
    push_req(MODE_MATRIX, 16'h7fff);
    push_req(MODE_MATRIX, 16'h0000);
    push_req(MODE_MATRIX, 16'hffff);
    push_req(MODE_MATRIX, 16'h0001);
    push_req(MODE_MATRIX, 16'h0001);
    settle();

    // zero dimensions count as one
    write_reg(REG_NUM_COLS, 0);
    write_reg(REG_NUM_ROWS, 0);
    push_req(MODE_MATRIX, 16'hffff);
    push_req(MODE_LOAD, 16'h0005);
    push_req(MODE_MATRIX, 16'h7fff);
    settle();

    // shrink the column count while a row is open
    write_reg(REG_NUM_COLS, 5);
    write_reg(REG_NUM_ROWS, 4);
    push_req(MODE_MATRIX, 16'h8000);
    push_req(MODE_MATRIX, 16'h7fff);
    push_req(MODE_MATRIX, 16'h8000);
    settle();
    write_reg(REG_NUM_COLS, 2);
    push_req(MODE_MATRIX, 16'h1234);
    settle();

    run_phase(4, 3, 0, 30);
    run_phase(1, 1024, 69, 100);
    run_phase(7, 5, 29, 12);
    run_phase(16, 2, 0, 6);
    run_phase(3, 1, 69, 30);
    run_phase(2, 6, 29, 40);
    run_phase(0, 2047, 0, 70);
    run_phase(5, 0, 69, 16);

    $display("covered %0d requests: %0d vector loads and %0d matrix elements",
             n_loads + n_matrix, n_loads, n_matrix);
    $display("checked %0d row sums over %0d register writes", n_rows, n_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== matrix_vector_multiply.f =====
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_regs.sv
hw/rtl/mvm_ctrl.sv
hw/rtl/mvm_dpath.sv
hw/rtl/matrix_vector_multiply.sv
bench/matrix_vector_multiply_test.sv
